### hdl/irccs_pkg.sv
package irccs_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int SKIP_W = 3;
    localparam int CFG_INDEX_W = 2;

    // Defaults for the top-level parameters
    localparam int TRUE_COLOR_SKIP_DEF = 6;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_CODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRUE_COLOR_CODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_OTHER_CODES = 2'd2;

    // Register reset values
    localparam logic [BYTE_W-1:0] COLOR_CODE_RST = 8'h03;
    localparam logic [BYTE_W-1:0] TRUE_COLOR_CODE_RST = 8'h04;

    // Character constants
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

    // One queue entry: the results caused by one input byte.
    // first result : b0 / v0, line_end = eol & ~two
    // second result: b1 (always a real byte), line_end = eol
    typedef struct packed {
        logic              two;
        logic [BYTE_W-1:0] b0;
        logic              v0;
        logic [BYTE_W-1:0] b1;
        logic              eol;
    } entry_t;

endpackage

### hdl/irc_format_code_stripper_core.sv
// IRC formatting code stripper.
// Input stream (s_*): one raw text byte per transfer in s_tdata, s_tlast marks
//   the final byte of a line. Output stream (m_*): one cleaned byte per
//   transfer in m_tdata, m_tuser = 1 when m_tdata carries a byte (0 for a bare
//   end-of-line marker), m_tlast on the last transfer of the line.
// Config port (cfg_*): index 0 color code, 1 true-color code, 2 keep other
//   codes (bit 0). Always ready; write only while the stream is idle.
// Path: an accepted byte goes through the parser, the queue and the output
//   register before it appears on m_*.
// Throughput: one input byte per cycle while the queue has room. A byte that
//   releases a held comma makes two output transfers, sent in turn; the
//   queue between parser and emitter absorbs that and downstream stalls.
// Stall: s_tready drops only when the QUEUE_DEPTH entry queue is full; the
//   output register holds its transfer until m_tready.
// Reset: aresetn synchronous active low; parser goes idle, queue empties,
//   config registers return to 3 / 4 / 0. No clearing pass is needed.
module irc_format_code_stripper_core #(
    parameter int TRUE_COLOR_SKIP = irccs_pkg::TRUE_COLOR_SKIP_DEF,
    parameter int QUEUE_DEPTH     = irccs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] in_byte
    input  logic                               s_tlast,   // end_of_line
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] out_byte
    output logic                               m_tuser,   // byte_valid
    output logic                               m_tlast,   // line_end
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [irccs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                         cfg_data
);

    logic              in_fire;
    logic              push;
    irccs_pkg::entry_t push_entry;
    irccs_pkg::entry_t head;
    logic              full, empty, pop;

    assign s_tready  = !full;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // front: parse state machine, one byte per cycle unless the queue is full, up to two results
    irccs_front #(
        .TRUE_COLOR_SKIP (TRUE_COLOR_SKIP)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_byte    (s_tdata),
        .in_eol     (s_tlast),
        .cfg_fire   (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_entry (push_entry)
    );

    // result queue between parser and emitter
    irccs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    // back: splits pairs into single transfers through the output register
    irccs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (m_tdata),
        .out_byte_valid (m_tuser),
        .out_line_end   (m_tlast)
    );

endmodule

### hdl/irccs_front.sv
module irccs_front #(
    parameter int TRUE_COLOR_SKIP = irccs_pkg::TRUE_COLOR_SKIP_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input byte stream
    input  logic                               in_fire,
    input  logic [irccs_pkg::BYTE_W-1:0]       in_byte,
    input  logic                               in_eol,
    // configuration writes
    input  logic                               cfg_fire,
    input  logic [irccs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [irccs_pkg::BYTE_W-1:0]       cfg_data,
    // to queue
    output logic                               push,
    output irccs_pkg::entry_t                  push_entry
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_FG1   = 3'd1;
    localparam logic [2:0] PH_FG2   = 3'd2;
    localparam logic [2:0] PH_COMMA = 3'd3;
    localparam logic [2:0] PH_HELD  = 3'd4;
    localparam logic [2:0] PH_BG2   = 3'd5;
    localparam logic [2:0] PH_SKIP  = 3'd6;

    localparam logic [irccs_pkg::SKIP_W-1:0] SKIP_LOAD =
        irccs_pkg::SKIP_W'(TRUE_COLOR_SKIP);

    logic [irccs_pkg::BYTE_W-1:0] color_code_reg;
    logic [irccs_pkg::BYTE_W-1:0] true_color_code_reg;
    logic                         keep_other_reg;

    logic [2:0]                   phase_reg, phase_next;
    logic [irccs_pkg::SKIP_W-1:0] skip_reg, skip_next;

    logic                         dig;
    logic                         idle_emit;
    logic [2:0]                   idle_phase;
    logic [irccs_pkg::SKIP_W-1:0] idle_skip;
    logic                         use_idle;
    logic                         flush_comma;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_code_reg      <= irccs_pkg::COLOR_CODE_RST;
            true_color_code_reg <= irccs_pkg::TRUE_COLOR_CODE_RST;
            keep_other_reg      <= 1'b0;
        end else if (cfg_fire) begin
            case (cfg_index)
                irccs_pkg::REG_COLOR_CODE:       color_code_reg <= cfg_data;
                irccs_pkg::REG_TRUE_COLOR_CODE:  true_color_code_reg <= cfg_data;
                irccs_pkg::REG_KEEP_OTHER_CODES: keep_other_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // what a byte does when seen outside any sequence
    always_comb begin
        dig        = (in_byte >= irccs_pkg::CH_ZERO) && (in_byte <= irccs_pkg::CH_NINE);
        idle_emit  = 1'b0;
        idle_phase = PH_IDLE;
        idle_skip  = skip_reg;
        if (in_byte == color_code_reg) begin
            idle_phase = PH_FG1;
        end else if (in_byte == true_color_code_reg) begin
            idle_skip  = SKIP_LOAD;
            idle_phase = (SKIP_LOAD != '0) ? PH_SKIP : PH_IDLE;
        end else if (in_byte < irccs_pkg::CH_SPACE) begin
            idle_emit = keep_other_reg;
        end else begin
            idle_emit = 1'b1;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        use_idle    = 1'b0;
        flush_comma = 1'b0;
        case (phase_reg)
            PH_FG1: begin
                if (dig) phase_next = PH_FG2;
                else     use_idle = 1'b1;
            end
            PH_FG2: begin
                if (dig)                              phase_next = PH_COMMA;
                else if (in_byte == irccs_pkg::CH_COMMA) phase_next = PH_HELD;
                else                                  use_idle = 1'b1;
            end
            PH_COMMA: begin
                if (in_byte == irccs_pkg::CH_COMMA) phase_next = PH_HELD;
                else                                use_idle = 1'b1;
            end
            PH_HELD: begin
                if (dig) begin
                    phase_next = PH_BG2;
                end else begin
                    flush_comma = 1'b1;
                    use_idle    = 1'b1;
                end
            end
            PH_BG2: begin
                phase_next = PH_IDLE;
                if (!dig) use_idle = 1'b1;
            end
            PH_SKIP: begin
                skip_next = skip_reg - 1'b1;
                if (skip_next == '0) phase_next = PH_IDLE;
            end
            default: use_idle = 1'b1;
        endcase
        if (use_idle) begin
            phase_next = idle_phase;
            skip_next  = idle_skip;
        end

        // pack up to two results
        push_entry.two = 1'b0;
        push_entry.v0  = 1'b1;
        push_entry.b0  = in_byte;
        push_entry.b1  = in_byte;
        push_entry.eol = in_eol;
        push           = 1'b0;
        if (flush_comma) begin
            push_entry.b0  = irccs_pkg::CH_COMMA;
            push_entry.two = use_idle && idle_emit;
            push           = 1'b1;
        end else if (use_idle && idle_emit) begin
            push = 1'b1;
        end

        // line end: flush a held comma, else a bare marker if nothing came out
        if (in_eol) begin
            if (phase_next == PH_HELD) begin
                push_entry.b0 = irccs_pkg::CH_COMMA;
            end else if (!push) begin
                push_entry.b0 = '0;
                push_entry.v0 = 1'b0;
            end
            push       = 1'b1;
            phase_next = PH_IDLE;
            skip_next  = '0;
        end
        push = push && in_fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            skip_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

### hdl/irccs_queue.sv
module irccs_queue #(
    parameter int DEPTH = irccs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  irccs_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output irccs_pkg::entry_t head,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    irccs_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### hdl/irccs_back.sv
module irccs_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  irccs_pkg::entry_t            head,
    input  logic                         empty,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [irccs_pkg::BYTE_W-1:0] out_byte,
    output logic                         out_byte_valid,
    output logic                         out_line_end
);

    logic                         valid_reg;
    logic [irccs_pkg::BYTE_W-1:0] byte_reg;
    logic                         bvalid_reg;
    logic                         lend_reg;
    logic                         second_reg;   // first of a pair already sent
    logic                         load;

    assign load = !empty && (!valid_reg || out_ready);
    // the entry leaves once its final result is loaded
    assign pop  = load && (second_reg || !head.two);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            if (load)           valid_reg <= 1'b1;
            else if (out_ready) valid_reg <= 1'b0;
            if (load) second_reg <= !pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (second_reg) begin
                byte_reg   <= head.b1;
                bvalid_reg <= 1'b1;
                lend_reg   <= head.eol;
            end else begin
                byte_reg   <= head.b0;
                bvalid_reg <= head.v0;
                lend_reg   <= head.eol && !head.two;
            end
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign out_byte_valid = bvalid_reg;
    assign out_line_end   = lend_reg;

endmodule

### bench/tb_irc_format_code_stripper_core.sv
module tb_irc_format_code_stripper_core;

    // Bytes swallowed after a true-color code (DUT runs with its default).
    localparam int SWALLOW_COUNT = irccs_pkg::TRUE_COLOR_SKIP_DEF;
    // Raw bytes queued per random phase; eight phases plus the directed lines.
    localparam int PHASE_ITEMS   = 150;
    localparam int RANDOM_PHASES = 8;
    // Receiver hold-off long enough to fill the internal queue and stall s_*.
    localparam int LONG_HOLD     = 64;
    // Cycles to let a stripped byte clear the pipe after the last result.
    localparam int DRAIN_SLACK   = 8;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT   = 1000;

    // Parser phase of the predictor.
    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_FG_FIRST,     // color code seen, first fg digit may follow
        PARSE_FG_SECOND,    // one fg digit seen
        PARSE_FG_DONE,      // two fg digits seen, only a comma continues
        PARSE_COMMA_HELD,   // comma after fg held back
        PARSE_BG_SECOND,    // one bg digit seen
        PARSE_SWALLOW       // dropping bytes after a true-color code
    } parse_phase_t;

    // One result transfer as seen on m_*.
    typedef struct packed {
        logic [irccs_pkg::BYTE_W-1:0] out_byte;
        logic                         byte_valid;
        logic                         line_end;
    } cleaned_t;

    // One raw transfer for s_*.
    typedef struct packed {
        logic [irccs_pkg::BYTE_W-1:0] data;
        logic                         eol;
    } raw_item_t;

    // Predicts the cleaned stream from accepted raw bytes and checks m_* against it.
    class strip_scoreboard;
        logic [irccs_pkg::BYTE_W-1:0] palette_code;
        logic [irccs_pkg::BYTE_W-1:0] rgb_code;
        logic                         pass_controls;
        parse_phase_t                 phase;
        logic [irccs_pkg::SKIP_W-1:0] bytes_to_swallow;
        cleaned_t                     cleaned_due[$];
        int unsigned                  errors;

        function new();
            palette_code     = irccs_pkg::COLOR_CODE_RST;
            rgb_code         = irccs_pkg::TRUE_COLOR_CODE_RST;
            pass_controls    = 1'b0;
            phase            = PARSE_IDLE;
            bytes_to_swallow = '0;
            errors           = 0;
        endfunction

        function void write_reg(input logic [irccs_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [irccs_pkg::BYTE_W-1:0] value);
            case (idx)
                irccs_pkg::REG_COLOR_CODE:       palette_code = value;
                irccs_pkg::REG_TRUE_COLOR_CODE:  rgb_code = value;
                irccs_pkg::REG_KEEP_OTHER_CODES: pass_controls = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return cleaned_due.size();
        endfunction

        function void emit(input logic [irccs_pkg::BYTE_W-1:0] b);
            cleaned_due.push_back('{b, 1'b1, 1'b0});
        endfunction

        // Byte seen outside any sequence; color code wins over true color.
        function void take_fresh_byte(input logic [irccs_pkg::BYTE_W-1:0] b);
            if (b == palette_code) begin
                phase = PARSE_FG_FIRST;
            end else if (b == rgb_code) begin
                bytes_to_swallow = irccs_pkg::SKIP_W'(SWALLOW_COUNT);
                phase = (bytes_to_swallow != 0) ? PARSE_SWALLOW : PARSE_IDLE;
            end else if (b < irccs_pkg::CH_SPACE) begin
                if (pass_controls)
                    emit(b);
            end else begin
                emit(b);
            end
        endfunction

        function void accept_raw_byte(input logic [irccs_pkg::BYTE_W-1:0] b,
                                      input logic eol);
            int unsigned first;
            logic        dig;
            first = cleaned_due.size();
            dig   = (b >= irccs_pkg::CH_ZERO) && (b <= irccs_pkg::CH_NINE);
            case (phase)
                PARSE_FG_FIRST: begin
                    if (dig) begin
                        phase = PARSE_FG_SECOND;
                    end else begin
                        phase = PARSE_IDLE;
                        take_fresh_byte(b);
                    end
                end
                PARSE_FG_SECOND: begin
                    if (dig) begin
                        phase = PARSE_FG_DONE;
                    end else if (b == irccs_pkg::CH_COMMA) begin
                        phase = PARSE_COMMA_HELD;
                    end else begin
                        phase = PARSE_IDLE;
                        take_fresh_byte(b);
                    end
                end
                PARSE_FG_DONE: begin
                    if (b == irccs_pkg::CH_COMMA) begin
                        phase = PARSE_COMMA_HELD;
                    end else begin
                        phase = PARSE_IDLE;
                        take_fresh_byte(b);
                    end
                end
                PARSE_COMMA_HELD: begin
                    if (dig) begin
                        phase = PARSE_BG_SECOND;
                    end else begin
                        // comma was not a bg separator: release it first
                        emit(irccs_pkg::CH_COMMA);
                        phase = PARSE_IDLE;
                        take_fresh_byte(b);
                    end
                end
                PARSE_BG_SECOND: begin
                    phase = PARSE_IDLE;
                    if (!dig)
                        take_fresh_byte(b);
                end
                PARSE_SWALLOW: begin
                    bytes_to_swallow = bytes_to_swallow - 1'b1;
                    if (bytes_to_swallow == 0)
                        phase = PARSE_IDLE;
                end
                default: begin
                    phase = PARSE_IDLE;
                    take_fresh_byte(b);
                end
            endcase

            if (eol) begin
                if (phase == PARSE_COMMA_HELD)
                    emit(irccs_pkg::CH_COMMA);
                phase = PARSE_IDLE;
                bytes_to_swallow = '0;
                if (cleaned_due.size() == first)
                    cleaned_due.push_back('{8'h00, 1'b0, 1'b0});
                cleaned_due[cleaned_due.size() - 1].line_end = 1'b1;
            end
        endfunction

        function void check_cleaned_byte(input logic [irccs_pkg::BYTE_W-1:0] b,
                                         input logic v, input logic l);
            cleaned_t want;
            if (cleaned_due.size() == 0) begin
                $error("unexpected output transfer: out_byte %02h byte_valid %0b line_end %0b",
                       b, v, l);
                errors++;
            end else begin
                want = cleaned_due.pop_front();
                if (b !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, b);
                    errors++;
                end
                if (v !== want.byte_valid) begin
                    $error("byte_valid: expected %0b, got %0b", want.byte_valid, v);
                    errors++;
                end
                if (l !== want.line_end) begin
                    $error("line_end: expected %0b, got %0b", want.line_end, l);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [7:0]                        s_tdata;    // [7:0] in_byte
    logic                              s_tlast;    // end_of_line
    logic                              m_tvalid;
    logic                              m_tready;
    logic [7:0]                        m_tdata;    // [7:0] out_byte
    logic                              m_tuser;    // byte_valid
    logic                              m_tlast;    // line_end
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [irccs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]                        cfg_data;

    strip_scoreboard sb;
    raw_item_t       line_items[$];     // raw bytes waiting to be sent
    bit              rx_quiet;          // receiver never stalls when set
    bit              hold_request;      // receiver does one long hold-off
    int unsigned     stall_cycles;      // cycles since the last transfer of any kind

    irc_format_code_stripper_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Transfer monitor. Everything is sampled at the rising edge, before any
    // nonblocking update of that edge lands, so the values seen are the ones
    // the DUT sampled. Raw bytes are noted before results of the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_cycles <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.accept_raw_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_cleaned_byte(m_tdata, m_tuser, m_tlast);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog: ends a hung run.
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request, none when quiet.
    // Every branch makes one assignment to m_tready and then waits on the clock.
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic void put_byte(input logic [7:0] b);
        line_items.push_back('{b, 1'b0});
    endfunction

    function automatic void end_line();
        line_items[line_items.size() - 1].eol = 1'b1;
    endfunction

    function automatic logic [7:0] random_digit();
        return irccs_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Mostly well-formed color and true-color sequences with random content,
    // mixed with plain text, control bytes and noise.
    function automatic void add_random_line(input logic [7:0] cc, input logic [7:0] tcc);
        int unsigned tokens;
        tokens = $urandom_range(1, 8);
        repeat (tokens) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    put_byte(cc);
                    repeat ($urandom_range(0, 2)) put_byte(random_digit());
                    if ($urandom_range(0, 1) == 1) begin
                        put_byte(irccs_pkg::CH_COMMA);
                        repeat ($urandom_range(0, 2)) put_byte(random_digit());
                    end
                end
                3: begin
                    // sometimes short of six bytes: cut by line end or next token
                    put_byte(tcc);
                    repeat ($urandom_range(0, 7)) put_byte(8'($urandom_range(0, 255)));
                end
                4, 5, 6: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(8'h20, 8'h7E)));
                7:       put_byte(8'($urandom_range(0, 8'h1F)));
                8:       put_byte(8'($urandom_range(0, 255)));
                default: put_byte(($urandom_range(0, 1) == 1) ? irccs_pkg::CH_COMMA
                                                              : random_digit());
            endcase
        end
        end_line();
    endfunction

    // Writes all three registers back to back; cfg_valid stays high between them.
    task automatic set_config(input logic [7:0] cc, input logic [7:0] tcc, input logic keep);
        cfg_valid <= 1'b1;
        cfg_index <= irccs_pkg::REG_COLOR_CODE;
        cfg_data  <= cc;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= irccs_pkg::REG_TRUE_COLOR_CODE;
        cfg_data  <= tcc;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= irccs_pkg::REG_KEEP_OTHER_CODES;
        cfg_data  <= {7'b0, keep};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Sends every queued raw byte. With gaps set, random idle bursts come
    // between transfers; tvalid only drops inside such a burst and at the end.
    task automatic send_items(input bit gaps);
        raw_item_t it;
        while (line_items.size() > 0) begin
            it = line_items.pop_front();
            if (gaps && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= it.data;
            s_tlast  <= it.eol;
            do @(posedge aclk); while (!s_tready);
        end
        s_tvalid <= 1'b0;
    endtask

    // Sender pause: wait until every predicted result has come, then let any
    // stripped byte still in flight clear the pipe.
    task automatic wait_drained();
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] cc;
        logic [7:0] tcc;
        logic       keep;
        bit         gaps;

        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rx_quiet     = 1'b0;
        hold_request = 1'b0;
        stall_cycles = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed lines at reset config (color 03, true color 04, strip all).
        // fg + bg color fully removed, non-digit after two bg digits is kept
        put_byte(8'h03); put_byte("1"); put_byte("2"); put_byte(irccs_pkg::CH_COMMA);
        put_byte("3"); put_byte("4"); put_byte("x"); end_line();
        // held comma released by a non-digit: two transfers from one byte
        put_byte(8'h03); put_byte("5"); put_byte(irccs_pkg::CH_COMMA); put_byte("y");
        end_line();
        // true color swallows six bytes; NUL dropped, 0xFF kept,
        // dropped last byte gives a bare end marker
        put_byte(8'h04);
        for (int i = 0; i < SWALLOW_COUNT; i++) put_byte(8'h61 + 8'(i));
        put_byte(8'h00); put_byte(8'hFF); put_byte(8'h1F); end_line();
        // held comma flushed at line end, carries line_end
        put_byte(8'h03); put_byte("7"); put_byte(irccs_pkg::CH_COMMA); end_line();
        // color code then non-digit; true color cut short by line end
        put_byte(8'h03); put_byte("q"); put_byte(8'h04); put_byte("a"); end_line();
        send_items(1'b1);
        wait_drained();

        // Both codes equal and above 0x20, control bytes passed through.
        set_config(8'h41, 8'h41, 1'b1);
        put_byte(8'h41); put_byte("9"); put_byte(irccs_pkg::CH_COMMA); put_byte(8'h00);
        put_byte(8'h1F); end_line();
        send_items(1'b1);
        wait_drained();

        // Random phases, each with its own register setting.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin cc = 8'h00; tcc = 8'hFF; keep = 1'b0; end
                1: begin cc = 8'hFF; tcc = 8'h00; keep = 1'b1; end
                2: begin
                    cc   = 8'($urandom_range(0, 255));
                    tcc  = cc;
                    keep = 1'($urandom_range(0, 1));
                end
                3: begin
                    cc   = irccs_pkg::COLOR_CODE_RST;
                    tcc  = irccs_pkg::TRUE_COLOR_CODE_RST;
                    keep = 1'b0;
                end
                RANDOM_PHASES - 1: begin
                    cc   = irccs_pkg::COLOR_CODE_RST;
                    tcc  = irccs_pkg::TRUE_COLOR_CODE_RST;
                    keep = 1'($urandom_range(0, 1));
                end
                default: begin
                    // mostly control-range codes, now and then any byte
                    cc   = 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 255 : 31));
                    tcc  = 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 255 : 31));
                    keep = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(cc, tcc, keep);

            while (line_items.size() < PHASE_ITEMS)
                add_random_line(cc, tcc);

            // phase 3: sender keeps offering while the receiver holds off,
            // so the queue fills and s_tready drops; last phase runs flat out
            gaps     = !(p == 3 || p == RANDOM_PHASES - 1);
            rx_quiet = (p == 5 || p == RANDOM_PHASES - 1);
            if (p == 3)
                hold_request = 1'b1;
            send_items(gaps);
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/irccs_pkg.sv
hdl/irccs_front.sv
hdl/irccs_queue.sv
hdl/irccs_back.sv
hdl/irc_format_code_stripper_core.sv
bench/tb_irc_format_code_stripper_core.sv
